// ===== design/mec_pkg.sv =====
package mec_pkg;

    localparam int FRAC_BITS = 60;
    localparam int MAX_DIM   = 4096;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] FOUR = 64'(64'd4 << FRAC_BITS);

    localparam int PROD_W = 75;

    localparam logic [7:0] CFG_CENTER_REAL    = 8'd0;
    localparam logic [7:0] CFG_CENTER_IMAG    = 8'd1;
    localparam logic [7:0] CFG_PIXEL_STEP     = 8'd2;
    localparam logic [7:0] CFG_NUM_COLS       = 8'd3;
    localparam logic [7:0] CFG_NUM_ROWS       = 8'd4;
    localparam logic [7:0] CFG_MAX_ITERATIONS = 8'd5;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [15:0] escape_count;
        logic        reached_limit;
    } t_result;

    typedef struct packed {
        logic [63:0] center_real;
        logic [63:0] center_imag;
        logic [62:0] pixel_step;
        logic [12:0] num_cols;
        logic [12:0] num_rows;
    } t_view;

    typedef struct packed {
        logic [63:0] c_re;
        logic [63:0] c_im;
    } t_coord;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (((a ^ s) & (b ^ s)) >> 63 != 64'd0) begin
            return a[63] ? SMIN : SMAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (((a ^ b) & (a ^ s)) >> 63 != 64'd0) begin
            return a[63] ? SMIN : SMAX;
        end
        return s;
    endfunction

    // Caps an exact unsigned product at the largest positive value.
    function automatic logic [63:0] cap_pos(input logic [PROD_W-1:0] v);
        if (v > PROD_W'(SMAX)) begin
            return SMAX;
        end
        return v[63:0];
    endfunction

    // Finishes a fixed-point product from the full magnitude product.
    function automatic logic [63:0] q_finish(input logic [127:0] prod, input logic neg);
        logic [127:0] sh;
        sh = prod >> FRAC_BITS;
        if (!neg) begin
            return (sh > {64'd0, SMAX}) ? SMAX : sh[63:0];
        end
        return (sh > {64'd0, SMIN}) ? SMIN : (64'd0 - sh[63:0]);
    endfunction

endpackage

// ===== design/mec_queue.sv =====
module mec_queue
    import mec_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_coord i_data,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_coord o_data
);

    t_coord     r_e0, r_e1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop, push;
    logic [1:0] slot;

    assign pop     = i_pop && (r_cnt != 2'd0);
    assign push    = i_push && (r_cnt != 2'd2);
    assign slot    = r_cnt - {1'b0, pop};
    assign n_cnt   = slot + {1'b0, push};
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_e0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_cnt == 2'd2) begin
            r_e0 <= r_e1;
        end
        if (push && slot == 2'd0) begin
            r_e0 <= i_data;
        end
        if (push && slot == 2'd1) begin
            r_e1 <= i_data;
        end
    end

endmodule

// ===== design/mec_front.sv =====
module mec_front
    import mec_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_view  i_view,
    input  logic   i_valid,
    input  t_pixel i_pixel,
    output logic   o_stall,
    output logic   o_push,
    output t_coord o_coord,
    input  logic   i_full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_CAP  = 5'b00100,
        F_SUM  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate           r_state;
    logic [11:0]       r_x, r_y;
    logic [3:0]        r_bit;
    logic [PROD_W-1:0] r_hx, r_hy, r_ox, r_oy;
    logic [63:0]       r_half_x, r_half_y, r_off_x, r_off_y;
    t_coord            r_coord;
    logic [11:0]       half_w, half_h, x_c, y_c;
    logic [PROD_W-1:0] step_w;
    logic [63:0]       step_half;

    assign half_w    = i_view.num_cols[12:1];
    assign half_h    = i_view.num_rows[12:1];
    assign step_w    = PROD_W'(i_view.pixel_step);
    assign step_half = 64'(i_view.pixel_step >> 1);
    assign x_c = (32'(i_pixel.pixel_x) > MAX_DIM - 1) ? 12'(MAX_DIM - 1) : i_pixel.pixel_x;
    assign y_c = (32'(i_pixel.pixel_y) > MAX_DIM - 1) ? 12'(MAX_DIM - 1) : i_pixel.pixel_y;

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_coord = r_coord;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: if (i_valid) r_state <= F_MUL;
                F_MUL:  if (r_bit == 4'd0) r_state <= F_CAP;
                F_CAP:  r_state <= F_SUM;
                F_SUM:  r_state <= F_PUSH;
                F_PUSH: if (!i_full) r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Shift-and-add products, most significant multiplier bit first.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_x   <= x_c;
                r_y   <= y_c;
                r_bit <= 4'd11;
                r_hx  <= '0;
                r_hy  <= '0;
                r_ox  <= '0;
                r_oy  <= '0;
            end
            F_MUL: begin
                r_hx  <= (r_hx << 1) + (half_w[r_bit] ? step_w : '0);
                r_hy  <= (r_hy << 1) + (half_h[r_bit] ? step_w : '0);
                r_ox  <= (r_ox << 1) + (r_x[r_bit] ? step_w : '0);
                r_oy  <= (r_oy << 1) + (r_y[r_bit] ? step_w : '0);
                r_bit <= r_bit - 4'd1;
            end
            F_CAP: begin
                r_half_x <= i_view.num_cols[0] ? sat_add(cap_pos(r_hx), step_half)
                                               : cap_pos(r_hx);
                r_half_y <= i_view.num_rows[0] ? sat_add(cap_pos(r_hy), step_half)
                                               : cap_pos(r_hy);
                r_off_x  <= cap_pos(r_ox);
                r_off_y  <= cap_pos(r_oy);
            end
            F_SUM: begin
                r_coord.c_re <= sat_add(sat_sub(i_view.center_real, r_half_x), r_off_x);
                r_coord.c_im <= sat_add(sat_sub(i_view.center_imag, r_half_y), r_off_y);
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/mec_back.sv =====
module mec_back
    import mec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_max_iter,
    input  logic        i_q_valid,
    input  t_coord      i_coord,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output t_result     o_result
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_CHK  = 6'b000010,
        B_MUL  = 6'b000100,
        B_FIN  = 6'b001000,
        B_TEST = 6'b010000,
        B_DONE = 6'b100000
    } t_bstate;

    t_bstate      r_state;
    logic [63:0]  r_cr, r_ci, r_zr, r_zi, r_mr, r_mi;
    logic [63:0]  r_r2, r_i2, r_p;
    logic [15:0]  r_count;
    logic [2:0]   r_step;
    logic [63:0]  r_pp_rr, r_pp_ii, r_pp_ri;
    logic [127:0] r_acc_rr, r_acc_ii, r_acc_ri;
    logic         r_ovalid;
    t_result      r_result;
    logic [31:0]  a_r, b_r, a_i, b_i;
    logic [127:0] pp_sh_rr, pp_sh_ii, pp_sh_ri;
    logic [6:0]   shamt;
    logic [63:0]  mag_sum;
    logic         out_free;

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_state == B_IDLE) && i_q_valid;
    assign o_valid  = r_ovalid;
    assign o_result = r_result;
    assign mag_sum  = sat_add(r_r2, r_i2);

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
    always_comb begin
        a_r = r_step[1] ? r_mr[63:32] : r_mr[31:0];
        b_r = r_step[0] ? r_mr[63:32] : r_mr[31:0];
        a_i = r_step[1] ? r_mi[63:32] : r_mi[31:0];
        b_i = r_step[0] ? r_mi[63:32] : r_mi[31:0];
        case (r_step)
            3'd1:    shamt = 7'd0;
            3'd2:    shamt = 7'd32;
            3'd3:    shamt = 7'd32;
            3'd4:    shamt = 7'd64;
            default: shamt = 7'd0;
        endcase
        pp_sh_rr = {64'd0, r_pp_rr} << shamt;
        pp_sh_ii = {64'd0, r_pp_ii} << shamt;
        pp_sh_ri = {64'd0, r_pp_ri} << shamt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == B_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: if (i_q_valid) r_state <= B_CHK;
                B_CHK:  r_state <= (r_count == i_max_iter) ? B_DONE : B_MUL;
                B_MUL:  if (r_step == 3'd4) r_state <= B_FIN;
                B_FIN:  r_state <= B_TEST;
                B_TEST: r_state <= (mag_sum >= FOUR) ? B_DONE : B_CHK;
                B_DONE: if (out_free) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_cr    <= i_coord.c_re;
                r_ci    <= i_coord.c_im;
                r_zr    <= i_coord.c_re;
                r_zi    <= i_coord.c_im;
                r_count <= 16'd0;
            end
            B_CHK: begin
                r_mr     <= r_zr[63] ? 64'd0 - r_zr : r_zr;
                r_mi     <= r_zi[63] ? 64'd0 - r_zi : r_zi;
                r_step   <= 3'd0;
                r_acc_rr <= '0;
                r_acc_ii <= '0;
                r_acc_ri <= '0;
            end
            B_MUL: begin
                r_pp_rr <= a_r * b_r;
                r_pp_ii <= a_i * b_i;
                r_pp_ri <= a_r * b_i;
                if (r_step != 3'd0) begin
                    r_acc_rr <= r_acc_rr + pp_sh_rr;
                    r_acc_ii <= r_acc_ii + pp_sh_ii;
                    r_acc_ri <= r_acc_ri + pp_sh_ri;
                end
                r_step <= r_step + 3'd1;
            end
            B_FIN: begin
                r_r2 <= q_finish(r_acc_rr, 1'b0);
                r_i2 <= q_finish(r_acc_ii, 1'b0);
                r_p  <= q_finish(r_acc_ri, r_zr[63] ^ r_zi[63]);
            end
            B_TEST: begin
                if (mag_sum < FOUR) begin
                    r_count <= r_count + 16'd1;
                    r_zi    <= sat_add(sat_add(r_p, r_p), r_ci);
                    r_zr    <= sat_add(sat_sub(r_r2, r_i2), r_cr);
                end
            end
            B_DONE: begin
                if (out_free) begin
                    r_result.escape_count  <= r_count;
                    r_result.reached_limit <= (r_count == i_max_iter);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/mandelbrot_escape_count.sv =====
// Escape-time counter: each transfer on the input carries one pixel position, which is
// mapped to a point c of the complex plane (signed fixed point, 60 fraction bits) around the
// configured center; z = z*z + c is iterated from z = c until |z|^2 reaches 4 or
// max_iterations is hit, and one result with the count and the limit flag is returned per
// pixel, in order. The coordinate stage runs ahead of the iteration engine through a
// two-entry queue. The iteration engine builds its 64x64 products from four 32x32 partial
// products per multiplier. The user must write configuration only while idle; the block
// itself does not enforce it.
module mandelbrot_escape_count
    import mec_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_pixel      i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_view       r_view;
    logic [15:0] r_max_iter;
    logic        push, full, q_valid, pop;
    t_coord      push_coord, q_coord;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view.center_real <= 64'd0;
            r_view.center_imag <= 64'd0;
            r_view.pixel_step  <= 63'd4611686018427388;
            r_view.num_cols    <= 13'd1024;
            r_view.num_rows    <= 13'd1024;
            r_max_iter         <= 16'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_REAL:    r_view.center_real <= i_cfg_data;
                CFG_CENTER_IMAG:    r_view.center_imag <= i_cfg_data;
                CFG_PIXEL_STEP:     r_view.pixel_step  <= i_cfg_data[62:0];
                CFG_NUM_COLS:       r_view.num_cols    <= i_cfg_data[12:0];
                CFG_NUM_ROWS:       r_view.num_rows    <= i_cfg_data[12:0];
                CFG_MAX_ITERATIONS: r_max_iter         <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    mec_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_view  (r_view),
        .i_valid (i_in_valid),
        .i_pixel (i_in_data),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_coord (push_coord),
        .i_full  (full)
    );

    mec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_coord),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (q_coord)
    );

    mec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_max_iter (r_max_iter),
        .i_q_valid  (q_valid),
        .i_coord    (q_coord),
        .o_pop      (pop),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_result   (o_out_data)
    );

endmodule

// ===== dv/tb_mandelbrot_escape_count.sv =====
`timescale 1ns / 1ps

module tb_mandelbrot_escape_count;
    import mec_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_pixel      i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_result     o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    mandelbrot_escape_count uut (.*);

    always #1 i_clk = ~i_clk;

    // View and iteration settings tracked by the predictor.
    logic [63:0] view_re, view_im;
    logic [62:0] view_step;
    logic [12:0] view_w, view_h;
    logic [15:0] iter_limit;

    t_result pending_results[$];
    int      errors = 0;
    int      pixels_sent = 0;
    int      results_seen = 0;
    int      limit_hits = 0;
    int      idle_cycles = 0;
    bit      hold_receiver = 1'b0;
    bit      bursty_receiver = 1'b1;

    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [63:0] sub_clamped(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [63:0] scale_capped(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return (p > {64'd0, SMAX}) ? SMAX : p[63:0];
    endfunction

    function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0]  ma, mb;
        logic [127:0] p;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p = ({64'd0, ma} * {64'd0, mb}) >> FRAC_BITS;
        if (a[63] ^ b[63]) return (p > {64'd0, SMIN}) ? SMIN : -p[63:0];
        return (p > {64'd0, SMAX}) ? SMAX : p[63:0];
    endfunction

    function automatic logic [63:0] plane_coord(logic [63:0] ctr, logic [12:0] size,
                                                logic [11:0] idx);
        logic [63:0] half, stp;
        stp = {1'b0, view_step};
        half = scale_capped({52'd0, size[12:1]}, stp);
        if (size[0]) half = add_clamped(half, stp >> 1);
        return add_clamped(sub_clamped(ctr, half), scale_capped({52'd0, idx}, stp));
    endfunction

    function automatic t_result escape_of(t_pixel px);
        logic [63:0] cr, ci, zr, zi, r2, i2, p;
        logic [16:0] n;
        t_result r;
        cr = plane_coord(view_re, view_w, px.pixel_x);
        ci = plane_coord(view_im, view_h, px.pixel_y);
        zr = cr;
        zi = ci;
        n = 0;
        while (n < iter_limit) begin
            r2 = fixed_mul(zr, zr);
            i2 = fixed_mul(zi, zi);
            if ($signed(add_clamped(r2, i2)) >= $signed(FOUR)) break;
            n++;
            p = fixed_mul(zr, zi);
            zi = add_clamped(add_clamped(p, p), ci);
            zr = add_clamped(sub_clamped(r2, i2), cr);
        end
        r.escape_count = n[15:0];
        r.reached_limit = (n[15:0] == iter_limit);
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit gaps = 1'b1);
        t_pixel px;
        int g;
        px.pixel_x = x;
        px.pixel_y = y;
        pending_results.push_back(escape_of(px));
        i_in_data <= px;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pixels_sent++;
        @(negedge i_clk);
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [63:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CENTER_REAL:    view_re = val;
            CFG_CENTER_IMAG:    view_im = val;
            CFG_PIXEL_STEP:     view_step = val[62:0];
            CFG_NUM_COLS:       view_w = val[12:0];
            CFG_NUM_ROWS:       view_h = val[12:0];
            CFG_MAX_ITERATIONS: iter_limit = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_view(logic [63:0] re, logic [63:0] im, logic [62:0] stp,
                            logic [12:0] w, logic [12:0] h, logic [15:0] lim);
        write_reg(CFG_CENTER_REAL, re);
        write_reg(CFG_CENTER_IMAG, im);
        write_reg(CFG_PIXEL_STEP, {1'b0, stp});
        write_reg(CFG_NUM_COLS, {51'd0, w});
        write_reg(CFG_NUM_ROWS, {51'd0, h});
        write_reg(CFG_MAX_ITERATIONS, {48'd0, lim});
    endtask

    task automatic test_reset_view();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd300, 12'd700);
        drain();
    endtask

    task automatic test_corner_cases();
        // Zero step collapses every pixel onto the center; zero size drops centering.
        set_view(64'hF800_0000_0000_0000, 64'd0, 63'd0, 13'd0, 13'd0, 16'd40);
        send_pixel(12'd4095, 12'd0);
        drain();
        set_view(64'd0, 64'd0, 63'd1 << 52, 13'd4096, 13'd4095, 16'd1);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd4095);
        drain();
        set_view(SMAX, SMIN, 63'h7FFF_FFFF_FFFF_FFFF, 13'd1, 13'd4096, 16'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();
        // Unknown register index must leave the view alone.
        write_reg(8'd6, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(8'hFF, 64'd0);
        set_view(SMIN, SMAX, 63'd1, 13'd7, 13'd3, 16'd3);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain();
        set_view(-64'sd1 <<< 58, 64'd0, 63'd1 << 50, 13'd64, 13'd64, 16'd600);
        send_pixel(12'd32, 12'd32);
        send_pixel(12'd0, 12'd32);
        drain();
    endtask

    task automatic test_backpressure();
        // Receiver holds off while the sender keeps offering pixels.
        set_view(-64'sd1 <<< 59, 64'd0, 63'd1 << 56, 13'd16, 13'd16, 16'd20);
        hold_receiver = 1'b1;
        fork
            begin
                repeat (400) @(negedge i_clk);
                hold_receiver = 1'b0;
            end
            repeat (12) send_pixel(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)),
                                   1'b0);
        join
        drain();
    endtask

    task automatic test_random_views();
        int v, k;
        logic [12:0] w, h;
        logic [15:0] lim;
        for (v = 0; v < 30; v++) begin
            w = 13'($urandom_range(1, 4096));
            h = 13'($urandom_range(1, 4096));
            lim = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 300))
                                               : 16'($urandom_range(1, 48));
            if (v % 2 == 0)
                set_view({$urandom, $urandom}, {$urandom, $urandom},
                         63'({$urandom, $urandom}), 13'($urandom), 13'($urandom),
                         16'($urandom_range(0, 12)));
            else
                set_view($signed(64'sd1 <<< 60) * $signed($urandom_range(0, 2)) -
                         (64'sd1 <<< 60), ({32'd0, $urandom} << 29) - (64'sd1 <<< 60),
                         63'(4.0 / w * 2.0 ** 60), w, h, lim);
            bursty_receiver = (v % 3 != 0);
            for (k = 0; k < 54; k++)
                if ($urandom_range(0, 9) == 0)
                    send_pixel(12'($urandom), 12'($urandom));
                else
                    send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
            drain();
        end
        bursty_receiver = 1'b1;
    endtask

    // Receiver side: stall pattern and result check.
    always @(negedge i_clk) begin
        if (hold_receiver) i_out_stall <= 1'b1;
        else if (!bursty_receiver) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 99) < 25) ||
                            ($urandom_range(0, 199) == 0);
    end

    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, o_out_data);
            end else begin
                exp = pending_results.pop_front();
                if (exp.reached_limit) limit_hits++;
                if (o_out_data.escape_count !== exp.escape_count) begin
                    errors++;
                    $display("%0t: escape_count expected %0d actual %0d", $time,
                             exp.escape_count, o_out_data.escape_count);
                end
                if (o_out_data.reached_limit !== exp.reached_limit) begin
                    errors++;
                    $display("%0t: reached_limit expected %0d actual %0d", $time,
                             exp.reached_limit, o_out_data.reached_limit);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        view_re = 64'd0;
        view_im = 64'd0;
        view_step = 63'd4611686018427388;
        view_w = 13'd1024;
        view_h = 13'd1024;
        iter_limit = 16'd256;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_view();
        test_corner_cases();
        test_backpressure();
        test_random_views();
        $display("Covered %0d pixels and %0d results over 30+ views; %0d hit the limit.",
                 pixels_sent, results_seen, limit_hits);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
